// ===== rtl/ssd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ssd_pkg
// Shared types, codes and digit helpers for the seven-segment display driver.
// ----------------------------------------------------------------------------
package ssd_pkg;

  // request codes
  typedef enum logic [2:0] {
    ACT_TICK     = 3'd0,
    ACT_TIME     = 3'd1,
    ACT_TEMP     = 3'd2,
    ACT_MSG_ON   = 3'd3,
    ACT_MSG_OFF  = 3'd4,
    ACT_MSG_AUTO = 3'd5
  } action_t;

  // configuration register indexes
  localparam logic CFG_HOLD_TICKS = 1'b0;
  localparam logic CFG_TEMP_ERROR = 1'b1;

  localparam logic [15:0] HOLD_TICKS_RST = 16'd3906;
  localparam logic [7:0]  TEMP_ERROR_RST = 8'h80;

  // fixed patterns, bit 0..6 = segments a..g, bit 7 = point, 1 = lit
  localparam logic [7:0] PAT_BLANK = 8'h00;
  localparam logic [7:0] PAT_DASH  = 8'h40;
  localparam logic [7:0] PAT_POINT = 8'h80;
  localparam logic [7:0] PAT_N     = 8'h54;
  localparam logic [7:0] PAT_O     = 8'h3f;
  localparam logic [7:0] PAT_F     = 8'h71;
  localparam logic [7:0] PAT_T     = 8'h78;
  localparam logic [7:0] PAT_U     = 8'h3e;
  localparam logic [7:0] PAT_A     = 8'h77;
  localparam logic [7:0] PAT_ALL   = 8'hff;

  typedef logic [3:0][7:0] pat_arr_t;

  // decoder to display-state control
  typedef struct packed {
    logic load;          // replace all digit patterns
    logic restart_hold;  // reload the hold counter
  } upd_t;

  // decimal digit to segment pattern
  function automatic logic [7:0] glyph(input logic [3:0] d);
    logic [7:0] g;
    case (d)
      4'd0:    g = 8'h3f;
      4'd1:    g = 8'h06;
      4'd2:    g = 8'h5b;
      4'd3:    g = 8'h4f;
      4'd4:    g = 8'h66;
      4'd5:    g = 8'h6d;
      4'd6:    g = 8'h7d;
      4'd7:    g = 8'h07;
      4'd8:    g = 8'h7f;
      4'd9:    g = 8'h6f;
      default: g = 8'h00;
    endcase
    return g;
  endfunction

  // x / 10 by reciprocal multiply, exact for any 8-bit x
  function automatic logic [4:0] div10(input logic [7:0] x);
    logic [15:0] p;
    p = 16'(x) * 16'd205;
    return p[15:11];
  endfunction

  // x % 10 given its quotient
  function automatic logic [3:0] rem10(input logic [7:0] x, input logic [4:0] q);
    logic [7:0] r;
    r = x - 8'(q) * 8'd10;
    return r[3:0];
  endfunction

endpackage
`default_nettype wire

// ===== rtl/ssd_decode.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ssd_decode
// Turns a time, temperature or message request into four digit patterns.
// ----------------------------------------------------------------------------
module ssd_decode (
  input  var ssd_pkg::action_t  action,
  input  wire logic [4:0]       hour,
  input  wire logic [5:0]       minute,
  input  wire logic [5:0]       second,
  input  wire logic [7:0]       temperature,
  input  wire logic [7:0]       temp_error_code,
  input  wire logic             hold_active,
  output ssd_pkg::upd_t         upd,
  output ssd_pkg::pat_arr_t     patterns
);
  import ssd_pkg::*;

  logic [4:0] min_tens;
  logic [3:0] min_ones;
  logic [4:0] hr_tens;
  logic [3:0] hr_ones;
  logic [7:0] point;
  logic       neg;
  logic [7:0] mag;
  logic [7:0] sign;
  logic [4:0] mag_q;
  logic [3:0] mag_ones;
  logic [4:0] mag_h;
  logic [3:0] mag_tens;
  pat_arr_t   time_pat;
  pat_arr_t   temp_pat;

  // time split into decimal digits
  always_comb begin
    min_tens = div10(8'(minute));
    min_ones = rem10(8'(minute), min_tens);
    hr_tens  = div10(8'(hour));
    hr_ones  = rem10(8'(hour), hr_tens);
    point    = second[0] ? PAT_BLANK : PAT_POINT;
    time_pat[0] = glyph(min_ones) | point;
    time_pat[1] = glyph(min_tens[3:0]) | point;
    time_pat[2] = glyph(hr_ones);
    time_pat[3] = (hour < 5'd10) ? PAT_BLANK : glyph(hr_tens[3:0]);
  end

  // temperature magnitude, sign and digits
  always_comb begin
    neg      = temperature[7];
    mag      = neg ? 8'(-temperature) : temperature;
    sign     = neg ? PAT_DASH : PAT_BLANK;
    mag_q    = div10(mag);
    mag_ones = rem10(mag, mag_q);
    mag_h    = div10(8'(mag_q));
    mag_tens = rem10(8'(mag_q), mag_h);
    if (temperature == temp_error_code) begin
      temp_pat = {PAT_BLANK, PAT_DASH, PAT_DASH, PAT_BLANK};
    end else if (mag < 8'd10) begin
      temp_pat = {PAT_BLANK, sign, glyph(mag[3:0]), PAT_BLANK};
    end else if (mag < 8'd100) begin
      temp_pat = {sign, glyph(mag_q[3:0]), glyph(mag_ones), PAT_BLANK};
    end else begin
      temp_pat = {PAT_BLANK, glyph(mag_h[3:0]), glyph(mag_tens), glyph(mag_ones)};
    end
  end

  // request select
  always_comb begin
    upd      = '0;
    patterns = time_pat;
    case (action)
      ACT_TIME: begin
        upd.load = !hold_active;
      end
      ACT_TEMP: begin
        upd.load = !hold_active;
        patterns = temp_pat;
      end
      ACT_MSG_ON: begin
        upd      = '{load: 1'b1, restart_hold: 1'b1};
        patterns = {PAT_BLANK, PAT_O, PAT_N, PAT_BLANK};
      end
      ACT_MSG_OFF: begin
        upd      = '{load: 1'b1, restart_hold: 1'b1};
        patterns = {PAT_BLANK, PAT_O, PAT_F, PAT_F};
      end
      ACT_MSG_AUTO: begin
        upd      = '{load: 1'b1, restart_hold: 1'b1};
        patterns = {PAT_A, PAT_U, PAT_T, PAT_O};
      end
      default: begin
        upd = '0;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/seven_segment_mux_display.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// seven_segment_mux_display
// Four-digit multiplexed seven-segment display controller.
// ----------------------------------------------------------------------------
// Takes one request per clock while in_ready is high. A request is captured in
// an input register and handled, once it may advance, by a single pass of
// decode logic that updates the digit patterns, scan position and hold counter;
// a tick request leaves its digit enable and segment lines in an output
// register, and out_valid rises as that register is loaded. A tick in the
// input register stalls while the output register is full and out_ready is
// low, and holds back the requests behind it; other requests never wait on
// out_ready themselves. Configuration writes take effect on the next clock
// edge.
module seven_segment_mux_display (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  in_action,
  input  wire logic [4:0]  in_hour,
  input  wire logic [5:0]  in_minute,
  input  wire logic [5:0]  in_second,
  input  wire logic [7:0]  in_temperature,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [3:0]       out_digit_enable,
  output logic [7:0]       out_segment_lines
);
  import ssd_pkg::*;

  logic [15:0] hold_ticks_r;
  logic [7:0]  temp_error_code_r;

  logic        in_valid_r;
  action_t     in_action_r;
  logic [4:0]  in_hour_r;
  logic [5:0]  in_minute_r;
  logic [5:0]  in_second_r;
  logic [7:0]  in_temperature_r;

  pat_arr_t    digit_patterns_r;
  logic [1:0]  scan_digit_r;
  logic [2:0]  scan_segment_r;
  logic [15:0] hold_count_r;

  logic        out_valid_r;
  logic [3:0]  out_digit_enable_r;
  logic [7:0]  out_segment_lines_r;

  logic        is_tick;
  logic        advance;
  upd_t        upd;
  pat_arr_t    dec_patterns;
  logic        seg_lit;
  logic [7:0]  seg_nxt;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_ticks_r      <= HOLD_TICKS_RST;
      temp_error_code_r <= TEMP_ERROR_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_HOLD_TICKS: hold_ticks_r      <= cfg_wdata;
        CFG_TEMP_ERROR: temp_error_code_r <= cfg_wdata[7:0];
        default:        hold_ticks_r      <= hold_ticks_r;
      endcase
    end
  end

  // handshake: a tick needs a free output slot, other requests always go
  assign is_tick  = (in_action_r == ACT_TICK);
  assign advance  = in_valid_r && (!is_tick || !out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_action_r      <= action_t'(in_action);
      in_hour_r        <= in_hour;
      in_minute_r      <= in_minute;
      in_second_r      <= in_second;
      in_temperature_r <= in_temperature;
    end
  end

  ssd_decode u_decode (
    .action          (in_action_r),
    .hour            (in_hour_r),
    .minute          (in_minute_r),
    .second          (in_second_r),
    .temperature     (in_temperature_r),
    .temp_error_code (temp_error_code_r),
    .hold_active     (hold_count_r != 16'd0),
    .upd             (upd),
    .patterns        (dec_patterns)
  );

  // scanned segment, active low
  always_comb begin
    seg_lit = digit_patterns_r[scan_digit_r][scan_segment_r];
    seg_nxt = PAT_ALL;
    if (seg_lit) begin
      seg_nxt[scan_segment_r] = 1'b0;
    end
  end

  // display state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      digit_patterns_r <= {PAT_ALL, PAT_ALL, PAT_ALL, PAT_ALL};
      scan_digit_r     <= '0;
      scan_segment_r   <= '0;
      hold_count_r     <= '0;
    end else if (advance) begin
      if (is_tick) begin
        scan_segment_r <= scan_segment_r + 3'd1;
        if (scan_segment_r == 3'd7) begin
          scan_digit_r <= scan_digit_r + 2'd1;
        end
        if (hold_count_r != 16'd0) begin
          hold_count_r <= hold_count_r - 16'd1;
        end
      end else begin
        if (upd.load) begin
          digit_patterns_r <= dec_patterns;
        end
        if (upd.restart_hold) begin
          hold_count_r <= hold_ticks_r;
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && is_tick) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && is_tick) begin
      out_digit_enable_r  <= 4'b0001 << scan_digit_r;
      out_segment_lines_r <= seg_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_digit_enable  = out_digit_enable_r;
  assign out_segment_lines = out_segment_lines_r;

endmodule
`default_nettype wire
